// File: sv/twfm_pkg.sv
// Package: types and constants shared by the trigger window fragment matcher.
package twfm_pkg;

   localparam logic [31:0] TRIG_MAGIC = 32'h5452_4947;
   localparam logic [63:0] SEQ_WINDOW = 64'd100;
   localparam logic [63:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef enum logic [1:0] {
      FUNC_FRAGMENT = 2'd0,
      FUNC_TRIGGER  = 2'd1,
      FUNC_READ     = 2'd2,
      FUNC_NONE     = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      MODE_SINGLE  = 2'd0,
      MODE_BUFFER  = 2'd1,
      MODE_WINDOW  = 2'd2,
      MODE_IGNORED = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_FRAGMENT = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_MISSED   = 3'd2,
      ST_NO_TRIG  = 3'd3,
      ST_OPEN     = 3'd4,
      ST_NO_DATA  = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      REG_MODE   = 3'd0,
      REG_OFFSET = 3'd1,
      REG_WIDTH  = 3'd2,
      REG_STALE  = 3'd3,
      REG_UNIQUE = 3'd4
   } reg_index_type;

   typedef struct packed {
      func_type    func;
      logic [63:0] item_timestamp;
      logic [31:0] fragment_tag;
      logic [31:0] packet_header;
      logic [63:0] trigger_sequence;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [63:0] event_number;
      logic [31:0] out_tag;
      logic [63:0] out_timestamp;
      logic        last;
   } rsp_type;

   typedef struct packed {
      mode_type    mode;
      logic [63:0] offset;
      logic [63:0] width;
      logic [63:0] stale;
      logic        unique_win;
   } cfg_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_TRIG_SCAN,
      S_TRIG_SHIFT,
      S_READ_DROP,
      S_READ_DECIDE,
      S_PRUNE,
      S_SCAN,
      S_EMIT,
      S_FINISH
   } state_type;

endpackage

// File: sv/twfm_req_if.sv
// Interfaces: request and response channels.
interface twfm_req_if import twfm_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface twfm_rsp_if import twfm_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: sv/twfm_fifo.sv
// Module: short request queue between intake and engine.
module twfm_fifo import twfm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output req_type out_data
);
   req_type    mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= in_data;
   end
endmodule

// File: sv/twfm_engine.sv
// Module: event engine holding fragment buffer and trigger queue.
module twfm_engine import twfm_pkg::*; #(
   parameter int BUFFER_DEPTH  = 16,
   parameter int TRIGGER_DEPTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);
   localparam int BW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int TW = $clog2(TRIGGER_DEPTH);
   localparam int BC = $clog2(BUFFER_DEPTH + 1);
   localparam int TC = $clog2(TRIGGER_DEPTH + 1);

   logic [63:0] ftime_ff [BUFFER_DEPTH];
   logic [31:0] ftag_ff  [BUFFER_DEPTH];
   logic [63:0] tseq_ff  [TRIGGER_DEPTH];
   logic [63:0] ttime_ff [TRIGGER_DEPTH];
   logic [BC-1:0] fcnt_ff;
   logic [TC-1:0] tcnt_ff;
   logic [63:0] evc_ff, newest_ff;

   state_type   state_ff, state_in;
   req_type     cur_ff;
   logic [BC-1:0] idx_ff, idx_in;
   logic [TC-1:0] tpos_ff, tpos_in;
   logic [63:0] lo_ff, hi_ff, lim_ff;
   logic        sent_ff;
   logic        start_ff, start_in;
   rsp_type     rsp_ff;
   logic        rv_ff;

   // engine actions, decided combinationally
   logic        take;
   logic        frag_app, frag_clr, frag_drop_head;
   logic        frag_rm;
   logic [BC-1:0] frag_rm_idx;
   logic        trig_pop, trig_ins_step, trig_ins_done;
   logic        evc_inc;
   logic        emit;
   rsp_type     emit_d;
   logic [63:0] lo_in, hi_in, lim_in;
   logic        sent_in;

   logic [BW-1:0] ix;
   logic [TW-1:0] tp;
   logic [63:0] ft;
   logic [63:0] tt0, lo_c, hi_c;
   logic [64:0] hsum;
   logic        slot_free;
   logic        last_frag;
   logic        in_win;

   assign ix = idx_ff[BW-1:0];
   assign tp = tpos_ff[TW-1:0];
   assign ft = ftime_ff[ix];
   assign slot_free = !rv_ff || out_ready;
   assign in_ready  = (state_ff == S_IDLE);
   assign take = in_valid && in_ready;
   assign out_valid = rv_ff;
   assign out_data  = rsp_ff;
   assign last_frag = (idx_ff + 1'b1 == fcnt_ff);
   assign tt0 = ttime_ff[0];
   assign lo_c = (tt0 > cfg.offset) ? tt0 - cfg.offset : 64'd0;
   assign hsum = {1'b0, lo_ff} + {1'b0, cfg.width};
   assign hi_c = hsum[64] ? ALL_ONES : hsum[63:0];
   assign in_win = (ft >= lo_ff) && (ft <= hi_ff);

   function automatic rsp_type mk(status_type s, logic [63:0] ev, logic [31:0] tg,
                                  logic [63:0] ts, logic lst);
      rsp_type r;
      r.status = s; r.event_number = ev; r.out_tag = tg;
      r.out_timestamp = ts; r.last = lst;
      return r;
   endfunction

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff; tpos_in = tpos_ff;
      frag_app = 1'b0; frag_clr = 1'b0; frag_drop_head = 1'b0;
      frag_rm = 1'b0; frag_rm_idx = idx_ff;
      trig_pop = 1'b0; trig_ins_step = 1'b0; trig_ins_done = 1'b0;
      evc_inc = 1'b0; emit = 1'b0;
      emit_d = mk(ST_NO_TRIG, evc_ff, 32'd0, 64'd0, 1'b1);
      lo_in = lo_ff; hi_in = hi_ff; lim_in = lim_ff; sent_in = sent_ff;
      start_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (take) begin
               case (in_data.func)
                  FUNC_FRAGMENT: begin
                     frag_app = 1'b1;
                     frag_clr = (cfg.mode == MODE_SINGLE) || (cfg.mode == MODE_IGNORED);
                     frag_drop_head = !frag_clr && (fcnt_ff == BC'(BUFFER_DEPTH));
                  end
                  FUNC_TRIGGER: begin
                     if (in_data.packet_header == TRIG_MAGIC &&
                         in_data.trigger_sequence >= evc_ff &&
                         in_data.trigger_sequence - evc_ff < SEQ_WINDOW &&
                         tcnt_ff != TC'(TRIGGER_DEPTH)) begin
                        tpos_in = tcnt_ff;
                        state_in = S_TRIG_SCAN;
                     end
                  end
                  FUNC_READ: begin
                     start_in = 1'b1;
                     state_in = S_READ_DROP;
                  end
                  default: ;
               endcase
            end
         end
         S_TRIG_SCAN: begin
            // walk from the tail, shifting entries greater than the new one
            if (tpos_ff != '0 && tseq_ff[TW'(tpos_ff - 1'b1)] > cur_ff.trigger_sequence) begin
               trig_ins_step = 1'b1;
               tpos_in = tpos_ff - 1'b1;
            end else begin
               trig_ins_done = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_READ_DROP: begin
            if (start_ff && cfg.mode == MODE_IGNORED && fcnt_ff == '0 && tcnt_ff == '0) begin
               start_in = 1'b1;
               if (slot_free) begin
                  emit = 1'b1;
                  state_in = S_IDLE;
               end
            end else if (start_ff && cfg.mode != MODE_IGNORED && tcnt_ff == '0) begin
               start_in = 1'b1;
               lim_in = (newest_ff > cfg.stale) ? newest_ff - cfg.stale : 64'd0;
               idx_in = '0;
               sent_in = 1'b1;
               if (cfg.mode == MODE_BUFFER || cfg.mode == MODE_WINDOW)
                  state_in = S_PRUNE;
               else if (slot_free) begin
                  emit = 1'b1;
                  state_in = S_IDLE;
               end
            end else if (tcnt_ff != '0 && tseq_ff[0] < evc_ff) begin
               trig_pop = 1'b1;
            end else begin
               lo_in = lo_c;
               state_in = S_READ_DECIDE;
            end
         end
         S_READ_DECIDE: begin
            hi_in = hi_c;
            idx_in = '0;
            sent_in = 1'b0;
            lim_in = (lo_ff > cfg.stale) ? lo_ff - cfg.stale : 64'd0;
            if (cfg.mode == MODE_IGNORED) begin
               if (tcnt_ff != '0 && tseq_ff[0] == evc_ff) trig_pop = 1'b1;
               state_in = S_EMIT;
            end else if (slot_free) begin
               if (tcnt_ff == '0 || tseq_ff[0] != evc_ff) begin
                  emit = 1'b1;
                  emit_d.status = ST_MISSED;
                  evc_inc = 1'b1;
                  state_in = S_IDLE;
               end else if (cfg.mode == MODE_WINDOW && newest_ff < hi_c) begin
                  emit = 1'b1;
                  emit_d.status = ST_OPEN;
                  state_in = S_IDLE;
               end else begin
                  trig_pop = 1'b1;
                  if (cfg.mode == MODE_SINGLE) begin
                     emit = 1'b1;
                     evc_inc = 1'b1;
                     state_in = S_IDLE;
                     if (fcnt_ff == '0) emit_d.status = ST_NO_DATA;
                     else begin
                        emit_d = mk(ST_FRAGMENT, evc_ff,
                                    ftag_ff[BW'(fcnt_ff - 1'b1)],
                                    ftime_ff[BW'(fcnt_ff - 1'b1)], 1'b1);
                        frag_rm = 1'b1;
                        frag_rm_idx = fcnt_ff - 1'b1;
                     end
                  end else if (cfg.mode == MODE_BUFFER) state_in = S_EMIT;
                  else state_in = S_SCAN;
               end
            end
         end
         S_PRUNE: begin
            if (idx_ff == fcnt_ff) begin
               if (slot_free) begin
                  emit = 1'b1;
                  state_in = S_IDLE;
               end
            end else if (ft < lim_ff) begin
               frag_rm = 1'b1;
            end else idx_in = idx_ff + 1'b1;
         end
         S_EMIT: begin
            // drain every fragment in order
            if (fcnt_ff == '0) begin
               if (slot_free) begin
                  emit = 1'b1;
                  emit_d.status = (cfg.mode == MODE_IGNORED) ? ST_NO_DATA : ST_EMPTY;
                  evc_inc = (cfg.mode != MODE_IGNORED);
                  state_in = S_IDLE;
               end
            end else if (slot_free) begin
               emit = 1'b1;
               emit_d = mk(ST_FRAGMENT, evc_ff, ftag_ff[ix], ft, last_frag);
               idx_in = idx_ff + 1'b1;
               if (last_frag) begin
                  frag_clr = 1'b1;
                  evc_inc = (cfg.mode != MODE_IGNORED);
                  state_in = S_IDLE;
               end
            end
         end
         S_SCAN: begin
            if (idx_ff == fcnt_ff) state_in = S_FINISH;
            else if (in_win) begin
               if (slot_free) begin
                  // hold the previous window item until the next is known
                  state_in = S_SCAN;
               end
            end else if (ft < lim_ff) frag_rm = 1'b1;
            else idx_in = idx_ff + 1'b1;
         end
         S_FINISH: begin
            if (slot_free) begin
               emit = 1'b1;
               evc_inc = 1'b1;
               state_in = S_IDLE;
               if (!sent_ff) emit_d.status = ST_EMPTY;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // window items go through a one-deep pending register so last can be set
   rsp_type pend_ff;
   logic    pend_v_ff;
   logic    win_hit;
   rsp_type pend_last;
   rsp_type rsp_in;
   logic    rv_in;
   assign win_hit = (state_ff == S_SCAN) && (idx_ff != fcnt_ff) && in_win
                    && (!pend_v_ff || slot_free);

   always_comb begin
      pend_last = pend_ff;
      pend_last.last = 1'b1;
      rv_in  = rv_ff && !out_ready;
      rsp_in = rsp_ff;
      if (win_hit && pend_v_ff) begin
         rsp_in = pend_ff;
         rv_in  = 1'b1;
      end else if (state_ff == S_FINISH && slot_free) begin
         rsp_in = pend_v_ff ? pend_last : emit_d;
         rv_in  = 1'b1;
      end else if (emit) begin
         rsp_in = emit_d;
         rv_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         fcnt_ff   <= '0;
         tcnt_ff   <= '0;
         evc_ff    <= 64'd1;
         newest_ff <= 64'd0;
         rv_ff     <= 1'b0;
         pend_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         rsp_ff   <= rsp_in;
         if (evc_inc) evc_ff <= evc_ff + 64'd1;
         if (win_hit) begin
            pend_ff   <= mk(ST_FRAGMENT, evc_ff, ftag_ff[ix], ft, 1'b0);
            pend_v_ff <= 1'b1;
         end else if (state_ff == S_FINISH && slot_free) begin
            pend_v_ff <= 1'b0;
         end
         if (frag_app) begin
            newest_ff <= in_data.item_timestamp;
            if (frag_clr) fcnt_ff <= BC'(1);
            else if (!frag_drop_head) fcnt_ff <= fcnt_ff + 1'b1;
         end else if (frag_clr) fcnt_ff <= '0;
         else if (frag_rm || (win_hit && cfg.unique_win)) fcnt_ff <= fcnt_ff - 1'b1;
         if (trig_pop) tcnt_ff <= tcnt_ff - 1'b1;
         else if (trig_ins_done) tcnt_ff <= tcnt_ff + 1'b1;
      end
      if (take) cur_ff <= in_data;
      idx_ff   <= (win_hit && !cfg.unique_win) ? idx_ff + 1'b1 : idx_in;
      tpos_ff  <= tpos_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      lim_ff   <= lim_in;
      sent_ff  <= sent_in || win_hit;
      start_ff <= start_in;
      // fragment store: append, clear and keep only the new item, drop head, or remove and compact
      for (int i = 0; i < BUFFER_DEPTH; i++) begin
         if (frag_app) begin
            if (frag_clr) begin
               if (i == 0) begin
                  ftime_ff[i] <= in_data.item_timestamp;
                  ftag_ff[i]  <= in_data.fragment_tag;
               end
            end else if (frag_drop_head) begin
               if (i == BUFFER_DEPTH - 1) begin
                  ftime_ff[i] <= in_data.item_timestamp;
                  ftag_ff[i]  <= in_data.fragment_tag;
               end else begin
                  ftime_ff[i] <= ftime_ff[i + 1];
                  ftag_ff[i]  <= ftag_ff[i + 1];
               end
            end else if (BC'(i) == fcnt_ff) begin
               ftime_ff[i] <= in_data.item_timestamp;
               ftag_ff[i]  <= in_data.fragment_tag;
            end
         end else if ((frag_rm || (win_hit && cfg.unique_win)) &&
                      BC'(i) >= frag_rm_idx && i < BUFFER_DEPTH - 1) begin
            ftime_ff[i] <= ftime_ff[i + 1];
            ftag_ff[i]  <= ftag_ff[i + 1];
         end
      end
      // trigger queue: pop from front, or on insert shift one place per step, then write the new entry
      for (int j = 0; j < TRIGGER_DEPTH; j++) begin
         if (trig_pop) begin
            if (j < TRIGGER_DEPTH - 1) begin
               tseq_ff[j]  <= tseq_ff[j + 1];
               ttime_ff[j] <= ttime_ff[j + 1];
            end
         end else if (trig_ins_step && TW'(j) == tp) begin
            tseq_ff[j]  <= tseq_ff[TW'(tpos_ff - 1'b1)];
            ttime_ff[j] <= ttime_ff[TW'(tpos_ff - 1'b1)];
         end else if (trig_ins_done && TW'(j) == tp) begin
            tseq_ff[j]  <= cur_ff.trigger_sequence;
            ttime_ff[j] <= cur_ff.item_timestamp;
         end
      end
   end
endmodule

// File: sv/trigger_window_fragment_matcher_core.sv
// Top level: trigger window fragment matcher core.
//  channel | dir | payload
//  req     | in  | func, item_timestamp, fragment_tag, packet_header, trigger_sequence
//  rsp     | out | status, event_number, out_tag, out_timestamp, last
//  csr     | in  | write enable, index, 64-bit data
// A fragment item is taken in the engine's idle state; a trigger is either dropped there
// or inserted in sequence order by a walk from the tail of the trigger queue. A readout
// drops stale triggers, then prunes, scans or sends the buffered fragments.
// A two-entry queue decouples intake from the engine.
// Reset is synchronous; a stalled rsp holds the engine at its next result.
module trigger_window_fragment_matcher_core import twfm_pkg::*; #(
   parameter int BUFFER_DEPTH  = 16,
   parameter int TRIGGER_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   twfm_req_if.sink    req,
   twfm_rsp_if.source  rsp,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_write_data
);
   cfg_type cfg_ff;
   logic    q_valid, q_ready;
   req_type q_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode       <= MODE_SINGLE;
         cfg_ff.offset     <= 64'd0;
         cfg_ff.width      <= 64'd0;
         cfg_ff.stale      <= ALL_ONES;
         cfg_ff.unique_win <= 1'b1;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_MODE:   cfg_ff.mode       <= mode_type'(csr_write_data[1:0]);
            REG_OFFSET: cfg_ff.offset     <= csr_write_data;
            REG_WIDTH:  cfg_ff.width      <= csr_write_data;
            REG_STALE:  cfg_ff.stale      <= csr_write_data;
            REG_UNIQUE: cfg_ff.unique_win <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   twfm_fifo u_fifo (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_ready(req.ready), .in_data(req.payload),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
   );

   twfm_engine #(.BUFFER_DEPTH(BUFFER_DEPTH), .TRIGGER_DEPTH(TRIGGER_DEPTH)) u_engine (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.payload)
   );

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.payload))
      else $error("response changed while stalled");
   a_tag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.payload.status != ST_FRAGMENT |-> rsp.payload.out_tag == 32'd0)
      else $error("tag set on non-fragment status");
endmodule
